// ===== hw/rtl/los_pkg.sv =====
// ----------------------------------------------------------------------------
// los_pkg
// Types, codes and fixed-point helpers for the wall occlusion block.
// ----------------------------------------------------------------------------
package los_pkg;

  localparam logic signed [31:0] SMAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [63:0] QONE64 = 64'sd16777216;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CFG_COUNT  = 2'd0,
    CFG_IGNORE = 2'd1,
    CFG_AXIS   = 2'd2
  } cfg_idx_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_LATCH = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_NEXT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  typedef enum logic [4:0] {
    ST_FL_T, ST_FL_U, ST_FL_V, ST_FL_UU, ST_FL_VV, ST_FL_RT, ST_FL_S1, ST_FL_S2,
    ST_FL_END,
    ST_CN_KZ, ST_CN_MZ, ST_CN_C, ST_CN_M, ST_CN_AA, ST_CN_BB, ST_CN_CC, ST_CN_D,
    ST_CN_AP, ST_CN_BP, ST_CN_T, ST_CN_MM, ST_CN_PX, ST_CN_PY, ST_CN_Q, ST_CN_TT,
    ST_CN_RT, ST_CN_END
  } step_t;

  function automatic logic signed [63:0] sx32(input logic signed [31:0] x);
    return 64'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > sx32(SMAX32)) return SMAX32;
    if (x < -sx32(SMAX32)) return -SMAX32;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] csat(input logic signed [31:0] x);
    return (x == 32'sh8000_0000) ? -SMAX32 : x;
  endfunction

  // trunc(p / 2^24) toward zero, saturated
  function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p[63] ? -((-p) >>> 24) : (p >>> 24);
    return sat32(q);
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    logic signed [64:0] s;
    s = 65'(x) + 65'(y);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic [63:0] umag(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic in_unit(input logic signed [63:0] s);
    return (s >= 64'sd0) && (s <= QONE64);
  endfunction

endpackage

// ===== hw/rtl/line_of_sight_wall_occlusion.sv =====
// ----------------------------------------------------------------------------
// line_of_sight_wall_occlusion
// Wall point writes go straight into the wall table. A query walks the contour
// one segment at a time; skipped segments go straight to the next one, while
// flat and cone segments wait on the shared 31-step divider and 32-step root unit.
// The first segment needs an extra table read.
// The result strobes after the last segment via S_DONE; a hit ends the walk.
// Reset clears control and configuration; the wall table is not cleared.
// ----------------------------------------------------------------------------
module line_of_sight_wall_occlusion
  import los_pkg::*;
#(
  parameter int MAX_WALL_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [9:0]         in_point_index,
  input  logic signed [31:0] in_wall_radius,
  input  logic signed [31:0] in_wall_height,
  input  logic signed [31:0] in_particle_x,
  input  logic signed [31:0] in_particle_y,
  input  logic signed [31:0] in_particle_z,
  input  logic signed [31:0] in_camera_x,
  input  logic signed [31:0] in_camera_y,
  input  logic signed [31:0] in_camera_z,
  output logic               out_valid,
  output logic               out_sight_blocked,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int AW = $clog2(MAX_WALL_POINTS);
  localparam int CW = AW + 1;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [10:0]  wall_point_count_r;
  logic         ignore_outer_wall_r;
  logic [30:0]  axis_radius_r;

  logic signed [31:0] px_r, py_r, pz_r, cx_r, cy_r, cz_r;
  logic signed [31:0] rn_r, zn_r, rp_r, zp_r;
  logic signed [31:0] t_r, u_r, v_r, c_r, m_r, tt_r;
  logic signed [63:0] acc_r, den_r, prod_r;
  logic [CW-1:0]      idx_r;
  logic               hit_r;
  logic               out_valid_r, out_blocked_r;

  logic signed [31:0] mul_a, mul_b;
  logic               div_go, root_go, seg_hit;
  logic signed [63:0] div_n, div_d;
  logic [63:0]        root_in;

  // divider
  logic               div_busy_r, div_neg_r, div_ovf_r;
  logic [4:0]         div_cnt_r;
  logic [65:0]        div_rem_r;
  logic [70:0]        div_dsr_r;
  logic [30:0]        div_quo_r;
  logic signed [31:0] div_q_r;
  logic [66:0]        div_cand;
  logic               div_ge;
  logic [30:0]        div_mag;

  // square root
  logic               root_busy_r;
  logic [4:0]         root_cnt_r;
  logic [63:0]        root_v_r, root_res_r, root_bit_r, root_sum;
  logic [31:0]        root_q_r;

  logic [63:0]        ram_rdata;
  logic [AW+9:0]      widx_ext;
  logic               wr_en;
  logic [31:0]        n32, cnt32;

  logic signed [63:0] dcz, dzs, dflat, wq, sq, den_v;
  logic signed [31:0] dr, a_s, b_s;
  logic               skip;

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_sight_blocked = out_blocked_r;

  assign cnt32    = 32'(wall_point_count_r);
  assign n32      = (cnt32 > 32'(MAX_WALL_POINTS)) ? 32'(MAX_WALL_POINTS) : cnt32;
  assign widx_ext = (AW + 10)'(in_point_index);
  assign wr_en    = start && !busy && (in_opcode == OP_WRITE) &&
                    (32'(in_point_index) < 32'(MAX_WALL_POINTS));

  los_ram #(.WIDTH(64), .DEPTH(MAX_WALL_POINTS)) u_wall_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (widx_ext[AW-1:0]),
    .wdata ({csat(in_wall_radius), csat(in_wall_height)}),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign dcz   = sx32(cz_r) - sx32(pz_r);
  assign dzs   = sx32(zp_r) - sx32(zn_r);
  assign dflat = sx32(rn_r) - sx32(rp_r);
  assign dr    = sat32(sx32(rp_r) - sx32(rn_r));
  assign a_s   = sat32(sx32(cx_r) - sx32(px_r));
  assign b_s   = sat32(sx32(cy_r) - sx32(py_r));
  assign wq    = 64'(root_q_r);
  assign sq    = prod_r + (sx32(div_q_r) <<< 24);
  assign den_v = acc_r - prod_r;

  assign skip = (ignore_outer_wall_r && rn_r > $signed({1'b0, axis_radius_r}) &&
                 rp_r > $signed({1'b0, axis_radius_r})) ||
                (zn_r < pz_r && zp_r < pz_r && zn_r < cz_r && zp_r < cz_r) ||
                (zn_r > pz_r && zp_r > pz_r && zn_r > cz_r && zp_r > cz_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mul_a     = '0;
    mul_b     = '0;
    div_go    = 1'b0;
    div_n     = '0;
    div_d     = '0;
    root_go   = 1'b0;
    root_in   = '0;
    seg_hit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_opcode == OP_QUERY) begin
          state_nxt = (n32 < 32'd2) ? S_DONE : S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_LATCH;
      S_LATCH: state_nxt = (idx_r == '0) ? S_FETCH : S_CHECK;
      S_CHECK: begin
        if (skip) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_EVAL;
          step_nxt  = (zp_r == zn_r) ? ST_FL_T : ST_CN_KZ;
        end
      end
      S_WAIT: begin
        if (!div_busy_r && !root_busy_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_NEXT: begin
        if (hit_r || !((32'(idx_r) + 32'd1) < n32)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      S_EVAL: begin
        case (step_r)
          ST_FL_T: begin
            if (cz_r == pz_r) begin
              state_nxt = S_NEXT;
            end else begin
              div_go    = 1'b1;
              div_n     = sx32(zn_r) - sx32(pz_r);
              div_d     = dcz;
              state_nxt = S_WAIT;
              step_nxt  = ST_FL_U;
            end
          end
          ST_FL_U: begin
            mul_a = a_s; mul_b = div_q_r; step_nxt = ST_FL_V;
          end
          ST_FL_V: begin
            mul_a = b_s; mul_b = t_r; step_nxt = ST_FL_UU;
          end
          ST_FL_UU: begin
            mul_a = u_r; mul_b = u_r; step_nxt = ST_FL_VV;
          end
          ST_FL_VV: begin
            mul_a = v_r; mul_b = v_r; step_nxt = ST_FL_RT;
          end
          ST_FL_RT: begin
            root_go   = 1'b1;
            root_in   = 64'(acc_r + prod_r);
            state_nxt = S_WAIT;
            step_nxt  = ST_FL_S1;
          end
          ST_FL_S1: begin
            if (rn_r == rp_r) begin
              state_nxt = S_NEXT;
            end else begin
              div_go    = 1'b1;
              div_n     = sx32(rn_r) + wq;
              div_d     = dflat;
              state_nxt = S_WAIT;
              step_nxt  = ST_FL_S2;
            end
          end
          ST_FL_S2: begin
            if (in_unit(sx32(div_q_r))) begin
              seg_hit   = 1'b1;
              state_nxt = S_NEXT;
            end else begin
              div_go    = 1'b1;
              div_n     = sx32(rn_r) - wq;
              div_d     = dflat;
              state_nxt = S_WAIT;
              step_nxt  = ST_FL_END;
            end
          end
          ST_FL_END: begin
            seg_hit   = in_unit(sx32(div_q_r));
            state_nxt = S_NEXT;
          end
          ST_CN_KZ: begin
            div_go = 1'b1; div_n = dcz; div_d = dzs;
            state_nxt = S_WAIT; step_nxt = ST_CN_MZ;
          end
          ST_CN_MZ: begin
            div_go = 1'b1; div_n = sx32(pz_r) - sx32(zn_r); div_d = dzs;
            state_nxt = S_WAIT; step_nxt = ST_CN_C;
          end
          ST_CN_C: begin
            mul_a = dr; mul_b = t_r; step_nxt = ST_CN_M;
          end
          ST_CN_M: begin
            mul_a = u_r; mul_b = dr; step_nxt = ST_CN_AA;
          end
          ST_CN_AA: begin
            mul_a = a_s; mul_b = a_s; step_nxt = ST_CN_BB;
          end
          ST_CN_BB: begin
            mul_a = b_s; mul_b = b_s; step_nxt = ST_CN_CC;
          end
          ST_CN_CC: begin
            mul_a = c_r; mul_b = c_r; step_nxt = ST_CN_D;
          end
          ST_CN_D: begin
            mul_a = c_r; mul_b = m_r;
            if (den_v == '0) begin
              seg_hit   = 1'b1;
              state_nxt = S_NEXT;
            end else begin
              step_nxt = ST_CN_AP;
            end
          end
          ST_CN_AP: begin
            mul_a = a_s; mul_b = px_r; step_nxt = ST_CN_BP;
          end
          ST_CN_BP: begin
            mul_a = b_s; mul_b = py_r; step_nxt = ST_CN_T;
          end
          ST_CN_T: begin
            div_go = 1'b1; div_n = sadd(acc_r, -prod_r); div_d = den_r;
            state_nxt = S_WAIT; step_nxt = ST_CN_MM;
          end
          ST_CN_MM: begin
            mul_a = m_r; mul_b = m_r; step_nxt = ST_CN_PX;
          end
          ST_CN_PX: begin
            mul_a = px_r; mul_b = px_r; step_nxt = ST_CN_PY;
          end
          ST_CN_PY: begin
            mul_a = py_r; mul_b = py_r; step_nxt = ST_CN_Q;
          end
          ST_CN_Q: begin
            div_go = 1'b1; div_n = acc_r - prod_r; div_d = den_r;
            state_nxt = S_WAIT; step_nxt = ST_CN_TT;
          end
          ST_CN_TT: begin
            mul_a = tt_r; mul_b = tt_r; step_nxt = ST_CN_RT;
          end
          ST_CN_RT: begin
            if (sq < 64'sd0) begin
              state_nxt = S_NEXT;
            end else begin
              root_go   = 1'b1;
              root_in   = 64'(sq);
              state_nxt = S_WAIT;
              step_nxt  = ST_CN_END;
            end
          end
          ST_CN_END: begin
            seg_hit   = in_unit(sx32(tt_r) + wq) || in_unit(sx32(tt_r) - wq);
            state_nxt = S_NEXT;
          end
          default: state_nxt = S_NEXT;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      step_r              <= ST_FL_T;
      wall_point_count_r  <= '0;
      ignore_outer_wall_r <= 1'b0;
      axis_radius_r       <= '0;
      out_valid_r         <= 1'b0;
      hit_r               <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (state_r == S_IDLE) begin
        hit_r <= 1'b0;
      end else if (seg_hit) begin
        hit_r <= 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_COUNT:  wall_point_count_r  <= cfg_data[10:0];
          CFG_IGNORE: ignore_outer_wall_r <= cfg_data[0];
          CFG_AXIS:   axis_radius_r       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == S_DONE) begin
      out_blocked_r <= hit_r;
    end
    unique case (state_r)
      S_IDLE: begin
        idx_r <= '0;
        px_r  <= csat(in_particle_x);
        py_r  <= csat(in_particle_y);
        pz_r  <= csat(in_particle_z);
        cx_r  <= csat(in_camera_x);
        cy_r  <= csat(in_camera_y);
        cz_r  <= csat(in_camera_z);
      end
      S_LATCH: begin
        rn_r <= rp_r;
        zn_r <= zp_r;
        rp_r <= ram_rdata[63:32];
        zp_r <= ram_rdata[31:0];
        if (idx_r == '0) begin
          idx_r <= CW'(1);
        end
      end
      S_NEXT: idx_r <= idx_r + CW'(1);
      S_EVAL: begin
        case (step_r)
          ST_FL_U:  t_r   <= div_q_r;
          ST_FL_V:  u_r   <= sat32(sx32(px_r) + sx32(mulq(prod_r)));
          ST_FL_UU: v_r   <= sat32(sx32(py_r) + sx32(mulq(prod_r)));
          ST_FL_VV: acc_r <= prod_r;
          ST_CN_MZ: t_r   <= div_q_r;
          ST_CN_C:  u_r   <= div_q_r;
          ST_CN_M:  c_r   <= mulq(prod_r);
          ST_CN_AA: m_r   <= sat32(sx32(rn_r) + sx32(mulq(prod_r)));
          ST_CN_BB: acc_r <= prod_r;
          ST_CN_CC: acc_r <= acc_r + prod_r;
          ST_CN_D:  den_r <= den_v;
          ST_CN_AP: acc_r <= prod_r;
          ST_CN_BP: acc_r <= sadd(acc_r, -prod_r);
          ST_CN_MM: tt_r  <= div_q_r;
          ST_CN_PX: acc_r <= prod_r;
          ST_CN_PY: acc_r <= acc_r - prod_r;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // divider: min(|n| * 2^24 / |d|, 2^31-1), seven integer then 24 fraction steps
  assign div_cand = (div_cnt_r >= 5'd7) ? {div_rem_r, 1'b0} : {1'b0, div_rem_r};
  assign div_ge   = ({4'b0, div_cand} >= div_dsr_r);
  assign div_mag  = div_ovf_r ? SMAX32[30:0] : {div_quo_r[29:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (div_go) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == 5'd30) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      div_cnt_r <= '0;
      div_rem_r <= {2'b0, umag(div_n)};
      div_dsr_r <= {1'b0, umag(div_d), 6'b0};
      div_quo_r <= '0;
      div_neg_r <= div_n[63] ^ div_d[63];
      div_ovf_r <= ({7'b0, umag(div_n)} >= {umag(div_d), 7'b0});
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 5'd1;
      div_rem_r <= div_ge ? 66'(div_cand - div_dsr_r[66:0]) : div_cand[65:0];
      div_quo_r <= {div_quo_r[29:0], div_ge};
      if (div_cnt_r < 5'd6) begin
        div_dsr_r <= div_dsr_r >> 1;
      end
      if (div_cnt_r == 5'd30) begin
        div_q_r <= div_neg_r ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
      end
    end
  end

  // floor square root, one result bit per step
  assign root_sum = root_res_r + root_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_busy_r <= 1'b0;
    end else if (root_go) begin
      root_busy_r <= 1'b1;
    end else if (root_busy_r && root_cnt_r == 5'd31) begin
      root_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (root_go) begin
      root_cnt_r <= '0;
      root_v_r   <= root_in;
      root_res_r <= '0;
      root_bit_r <= 64'h4000_0000_0000_0000;
    end else if (root_busy_r) begin
      root_cnt_r <= root_cnt_r + 5'd1;
      root_bit_r <= root_bit_r >> 2;
      if (root_v_r >= root_sum) begin
        root_v_r   <= root_v_r - root_sum;
        root_res_r <= (root_res_r >> 1) + root_bit_r;
      end else begin
        root_res_r <= root_res_r >> 1;
      end
      if (root_cnt_r == 5'd31) begin
        root_q_r <= (root_v_r >= root_sum) ? 32'((root_res_r >> 1) + root_bit_r)
                                           : 32'(root_res_r >> 1);
      end
    end
  end

endmodule

// ===== hw/rtl/los_ram.sv =====
// ----------------------------------------------------------------------------
// los_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module los_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/los_checker.sv =====
// ----------------------------------------------------------------------------
// los_checker
// Port-level checks on command transfers and result strobes.
// ----------------------------------------------------------------------------
module los_checker
  import los_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_opcode,
  input logic out_valid
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_QUERY |=> busy)
    else $error("query transfer did not start work");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind line_of_sight_wall_occlusion los_checker u_los_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_opcode (in_opcode),
  .out_valid (out_valid)
);
